// File: hdl/m3i_pkg.sv
package m3i_pkg;

  // element format
  localparam int ELEM_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  localparam int NCOF = 9;                        // cofactors, one per inverse element
  localparam int NMUL = 2 * NCOF;                 // products feeding the cofactors
  localparam int PW   = 2 * ELEM_WIDTH;           // element product
  localparam int CSW  = 2 * ELEM_WIDTH + 1;       // signed cofactor
  localparam int CW   = 2 * ELEM_WIDTH;           // cofactor magnitude
  localparam int DW   = 3 * ELEM_WIDTH;           // determinant magnitude
  localparam int DETW = 3 * ELEM_WIDTH + 1;       // signed determinant
  localparam int NW   = CW + 2 * FRAC_BITS;       // dividend
  localparam int QW   = ELEM_WIDTH + 1;           // quotient bits developed
  localparam int DQW  = DW - 2 * FRAC_BITS;       // determinant back in element format

  localparam int Q_DEPTH = 4;

  // operand pairs: cofactor k = a[MUL_A[2k]]*a[MUL_B[2k]] - a[MUL_A[2k+1]]*a[MUL_B[2k+1]]
  localparam logic [3:0] MUL_A [NMUL] = '{4'd4, 4'd5, 4'd2, 4'd1, 4'd1, 4'd2, 4'd5, 4'd3, 4'd0,
                                          4'd2, 4'd2, 4'd0, 4'd3, 4'd4, 4'd1, 4'd0, 4'd0, 4'd1};
  localparam logic [3:0] MUL_B [NMUL] = '{4'd8, 4'd7, 4'd7, 4'd8, 4'd5, 4'd4, 4'd6, 4'd8, 4'd8,
                                          4'd6, 4'd3, 4'd5, 4'd7, 4'd6, 4'd6, 4'd7, 4'd4, 4'd3};

  typedef struct packed {
    logic signed [ELEM_WIDTH-1:0] in_r1c1;
    logic signed [ELEM_WIDTH-1:0] in_r1c2;
    logic signed [ELEM_WIDTH-1:0] in_r1c3;
    logic signed [ELEM_WIDTH-1:0] in_r2c1;
    logic signed [ELEM_WIDTH-1:0] in_r2c2;
    logic signed [ELEM_WIDTH-1:0] in_r2c3;
    logic signed [ELEM_WIDTH-1:0] in_r3c1;
    logic signed [ELEM_WIDTH-1:0] in_r3c2;
    logic signed [ELEM_WIDTH-1:0] in_r3c3;
  } in_item_t;

  typedef struct packed {
    logic signed [ELEM_WIDTH-1:0] inv_r1c1;
    logic signed [ELEM_WIDTH-1:0] inv_r1c2;
    logic signed [ELEM_WIDTH-1:0] inv_r1c3;
    logic signed [ELEM_WIDTH-1:0] inv_r2c1;
    logic signed [ELEM_WIDTH-1:0] inv_r2c2;
    logic signed [ELEM_WIDTH-1:0] inv_r2c3;
    logic signed [ELEM_WIDTH-1:0] inv_r3c1;
    logic signed [ELEM_WIDTH-1:0] inv_r3c2;
    logic signed [ELEM_WIDTH-1:0] inv_r3c3;
    logic signed [ELEM_WIDTH-1:0] det_value;
    logic                         is_singular;
    logic                         saturated;
  } out_item_t;

  // one classified request waiting for division
  typedef struct packed {
    logic                     zero;
    logic                     dneg;
    logic [DW-1:0]            dmag;
    logic [NCOF-1:0]          cneg;
    logic [NCOF-1:0][CW-1:0]  cmag;
  } entry_t;

endpackage

// File: hdl/m3i_front.sv
module m3i_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  m3i_pkg::in_item_t  in_data,
  output logic               push,
  output m3i_pkg::entry_t    push_data,
  input  logic               full
);
  import m3i_pkg::*;

  localparam int NSTG = 7;
  localparam int LW   = 2 * ELEM_WIDTH + 1;
  localparam int SW   = 2 * ELEM_WIDTH + 3;
  localparam int FW   = 3 * ELEM_WIDTH + 3;

  logic [NSTG-1:0] vld_r;
  logic            en;

  logic signed [ELEM_WIDTH-1:0] a_in [NCOF];
  logic signed [ELEM_WIDTH-1:0] a_r  [NCOF];
  logic signed [PW-1:0]         p_r  [NMUL];
  logic signed [ELEM_WIDTH-1:0] a2_r [3];
  logic signed [ELEM_WIDTH-1:0] a3_r [3];
  logic signed [CSW-1:0]        c3_r [NCOF];
  logic signed [CSW-1:0]        c4_r [NCOF];
  logic signed [CSW-1:0]        c5_r [NCOF];
  logic signed [CSW-1:0]        c6_r [NCOF];
  logic signed [LW-1:0]         lo_r [3];
  logic signed [LW-1:0]         hi_r [3];
  logic signed [SW-1:0]         slo_r;
  logic signed [SW-1:0]         shi_r;
  logic signed [FW-1:0]         slo_ext;
  logic signed [FW-1:0]         det_full;
  logic signed [DETW-1:0]       det_r;
  logic signed [DETW-1:0]       det_neg;
  logic signed [CSW-1:0]        c_neg [NCOF];
  entry_t                       ent_nxt;
  entry_t                       ent_r;

  assign en       = !vld_r[NSTG-1] || !full;
  assign in_stall = !en;
  assign push     = vld_r[NSTG-1] && !full;
  assign push_data = ent_r;

  assign a_in[0] = in_data.in_r1c1;
  assign a_in[1] = in_data.in_r1c2;
  assign a_in[2] = in_data.in_r1c3;
  assign a_in[3] = in_data.in_r2c1;
  assign a_in[4] = in_data.in_r2c2;
  assign a_in[5] = in_data.in_r2c3;
  assign a_in[6] = in_data.in_r3c1;
  assign a_in[7] = in_data.in_r3c2;
  assign a_in[8] = in_data.in_r3c3;

  assign slo_ext  = slo_r;
  assign det_full = $signed({shi_r, {ELEM_WIDTH{1'b0}}}) + slo_ext;
  assign det_neg  = -det_r;

  always_comb begin
    for (int k = 0; k < NCOF; k++) begin
      c_neg[k]        = -c6_r[k];
      ent_nxt.cneg[k] = c6_r[k][CSW-1];
      ent_nxt.cmag[k] = c6_r[k][CSW-1] ? c_neg[k][CW-1:0] : c6_r[k][CW-1:0];
    end
    ent_nxt.dneg = det_r[DETW-1];
    ent_nxt.dmag = det_r[DETW-1] ? det_neg[DW-1:0] : det_r[DW-1:0];
    ent_nxt.zero = (det_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= a_in;
      for (int j = 0; j < NMUL; j++) begin
        p_r[j] <= PW'(a_r[MUL_A[j]]) * PW'(a_r[MUL_B[j]]);
      end
      for (int m = 0; m < 3; m++) begin
        a2_r[m] <= a_r[3 * m];
        a3_r[m] <= a2_r[m];
      end
      for (int k = 0; k < NCOF; k++) begin
        c3_r[k] <= {p_r[2 * k][PW-1], p_r[2 * k]} - {p_r[2 * k + 1][PW-1], p_r[2 * k + 1]};
      end
      // determinant partials: cofactor split into unsigned low and signed high halves
      for (int m = 0; m < 3; m++) begin
        lo_r[m] <= LW'(a3_r[m]) * LW'($signed({1'b0, c3_r[m][ELEM_WIDTH-1:0]}));
        hi_r[m] <= LW'(a3_r[m]) * LW'($signed(c3_r[m][CSW-1:ELEM_WIDTH]));
      end
      c4_r  <= c3_r;
      slo_r <= SW'(lo_r[0]) + SW'(lo_r[1]) + SW'(lo_r[2]);
      shi_r <= SW'(hi_r[0]) + SW'(hi_r[1]) + SW'(hi_r[2]);
      c5_r  <= c4_r;
      det_r <= det_full[DETW-1:0];
      c6_r  <= c5_r;
      ent_r <= ent_nxt;
    end
  end

endmodule

// File: hdl/m3i_fifo.sv
module m3i_fifo #(
  parameter int DEPTH = m3i_pkg::Q_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  m3i_pkg::entry_t  push_data,
  output logic             full,
  input  logic             pop,
  output m3i_pkg::entry_t  pop_data,
  output logic             empty
);
  import m3i_pkg::*;

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  entry_t          mem_r [DEPTH];
  logic [PTRW-1:0] wr_r, rd_r;
  logic [CNTW-1:0] cnt_r;

  assign full     = (cnt_r == CNTW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PTRW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == PTRW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

// File: hdl/m3i_back.sv
module m3i_back (
  input  logic               clk,
  input  logic               rst_n,
  input  m3i_pkg::entry_t    head,
  input  logic               empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output m3i_pkg::out_item_t out_data
);
  import m3i_pkg::*;

  typedef enum logic [1:0] {B_IDLE, B_RUN, B_DONE} bstate_t;

  localparam int CNTW = $clog2(QW);
  localparam int R0W  = NW - QW;

  bstate_t         state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_r, out_nxt;
  logic            load, step, wr_out, out_free;

  logic [DW-1:0]   rem_r  [NCOF];
  logic [QW-1:0]   nlow_r [NCOF];
  logic [QW-1:0]   q_r    [NCOF];
  logic [NCOF-1:0] ovf_r;
  logic [NCOF-1:0] neg_r;
  logic            dneg_r, zero_r;
  logic [DW-1:0]   dmag_r;

  logic [NW-1:0]   nfull  [NCOF];
  logic [DW-1:0]   r0     [NCOF];
  logic [DW:0]     t      [NCOF];
  logic [DW:0]     diff   [NCOF];
  logic [DW-1:0]   rem_nx [NCOF];
  logic [NCOF-1:0] qbit;

  logic [QW-1:0]          lim, qn;
  logic [DQW-1:0]         dlim, dq, dqn;
  logic signed [ELEM_WIDTH-1:0] res [NCOF];
  logic signed [ELEM_WIDTH-1:0] dres;
  logic                   sat_any;

  assign pop       = load;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;

  // restoring division, one quotient bit per lane per cycle
  always_comb begin
    for (int k = 0; k < NCOF; k++) begin
      nfull[k]  = {head.cmag[k], {(2 * FRAC_BITS){1'b0}}};
      r0[k]     = {{(DW - R0W){1'b0}}, nfull[k][NW-1:QW]};
      t[k]      = {rem_r[k], nlow_r[k][QW-1]};
      diff[k]   = t[k] - {1'b0, dmag_r};
      qbit[k]   = (t[k] >= {1'b0, dmag_r});
      rem_nx[k] = qbit[k] ? diff[k][DW-1:0] : t[k][DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dneg_r <= head.dneg;
      dmag_r <= head.dmag;
      zero_r <= head.zero;
      for (int k = 0; k < NCOF; k++) begin
        rem_r[k]  <= r0[k];
        nlow_r[k] <= nfull[k][QW-1:0];
        q_r[k]    <= '0;
        ovf_r[k]  <= (r0[k] >= head.dmag);
        neg_r[k]  <= head.cneg[k] ^ head.dneg;
      end
    end else if (step) begin
      for (int k = 0; k < NCOF; k++) begin
        rem_r[k]  <= rem_nx[k];
        nlow_r[k] <= {nlow_r[k][QW-2:0], 1'b0};
        q_r[k]    <= {q_r[k][QW-2:0], qbit[k]};
      end
    end
  end

  // saturate and pack the finished result, or flag a singular matrix
  always_comb begin
    lim     = QW'(1) << (ELEM_WIDTH - 1);
    dlim    = DQW'(1) << (ELEM_WIDTH - 1);
    sat_any = 1'b0;
    qn      = '0;
    for (int k = 0; k < NCOF; k++) begin
      qn = -q_r[k];
      if (!neg_r[k] && (ovf_r[k] || q_r[k] >= lim)) begin
        res[k]  = {1'b0, {(ELEM_WIDTH - 1){1'b1}}};
        sat_any = 1'b1;
      end else if (neg_r[k] && (ovf_r[k] || q_r[k] > lim)) begin
        res[k]  = {1'b1, {(ELEM_WIDTH - 1){1'b0}}};
        sat_any = 1'b1;
      end else begin
        res[k] = neg_r[k] ? qn[ELEM_WIDTH-1:0] : q_r[k][ELEM_WIDTH-1:0];
      end
    end
    dq  = dmag_r[DW-1:2*FRAC_BITS];
    dqn = -dq;
    if (!dneg_r && dq >= dlim) begin
      dres    = {1'b0, {(ELEM_WIDTH - 1){1'b1}}};
      sat_any = 1'b1;
    end else if (dneg_r && dq > dlim) begin
      dres    = {1'b1, {(ELEM_WIDTH - 1){1'b0}}};
      sat_any = 1'b1;
    end else begin
      dres = dneg_r ? dqn[ELEM_WIDTH-1:0] : dq[ELEM_WIDTH-1:0];
    end

    out_nxt.inv_r1c1    = res[0];
    out_nxt.inv_r1c2    = res[1];
    out_nxt.inv_r1c3    = res[2];
    out_nxt.inv_r2c1    = res[3];
    out_nxt.inv_r2c2    = res[4];
    out_nxt.inv_r2c3    = res[5];
    out_nxt.inv_r3c1    = res[6];
    out_nxt.inv_r3c2    = res[7];
    out_nxt.inv_r3c3    = res[8];
    out_nxt.det_value   = dres;
    out_nxt.is_singular = 1'b0;
    out_nxt.saturated   = sat_any;
    if (zero_r) begin
      out_nxt             = '0;
      out_nxt.is_singular = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    load      = 1'b0;
    step      = 1'b0;
    wr_out    = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!empty) begin
          load      = 1'b1;
          state_nxt = B_RUN;
        end
      end
      B_RUN: begin
        step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (out_free) begin
          wr_out = 1'b1;
          if (!empty) begin
            load      = 1'b1;
            state_nxt = B_RUN;
          end else begin
            state_nxt = B_IDLE;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
    cnt_nxt       = load ? CNTW'(QW - 1) : (step ? cnt_r - 1'b1 : cnt_r);
    out_valid_nxt = wr_out || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (wr_out) begin
      out_r <= out_nxt;
    end
  end

endmodule

// File: hdl/matrix3_inverse_adjugate.sv
// 3x3 fixed-point matrix inverse by adjugate. One request carries a Q16.16
// matrix; one result carries the nine inverse elements, the determinant in
// Q16.16 and the singular and saturated flags. The front accepts a matrix
// every cycle unless stalled, and forms the cofactors and the exact
// determinant in seven registered stages of multipliers and adders.
// Finished requests wait in a queue of QUEUE_DEPTH entries. The back runs
// nine restoring dividers side by side, one quotient bit per cycle, to
// develop the QW quotient bits of each Q16.16 element; in a last state the
// result is saturated and registered while the next request is loaded. The
// divider loop sets the sustained rate; from an idle block a request passes
// the seven front stages, is written into the queue and is loaded before
// its quotient steps begin.
// The front keeps taking requests until the queue and its pipeline fill, and
// the output register lets the back start the next request while a result
// waits to be taken.
module matrix3_inverse_adjugate #(
  parameter int QUEUE_DEPTH = m3i_pkg::Q_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  m3i_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output m3i_pkg::out_item_t out_data
);
  import m3i_pkg::*;

  // front to queue
  logic   q_push, q_full;
  entry_t q_wdata;
  // queue to back
  logic   q_pop, q_empty;
  entry_t q_rdata;

  // cofactors and determinant, fully pipelined
  m3i_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full)
  );

  // decouples the front, one matrix per cycle unless stalled, from the bit-serial back
  m3i_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // nine dividers, saturation and the output register
  m3i_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_rdata),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
